// File: design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes for the keyed value table
// Request mode codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: design/keyed_value_table_top.sv
// ----------------------------------------------------------------------------
// keyed_value_table_top: packed key/value table with linear search
// Insert, erase, lookup, count-by-value and clear over a table kept in
// insertion order, using one sequenced read port and one compare stage.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on i_in_valid / o_in_stall (i_mode, i_req_key,
//   i_req_value). One result word per request leaves on o_out_valid /
//   i_out_stall.
//   A request passes from accept to result through an accept step, a scan
//   that reads one entry per cycle through the table memory (registered
//   read, so each compare follows its read), and a step to post the result.
//   An erase that hits continues with a shift pass of one entry per cycle
//   over the entries above the match. Clear and unknown modes skip the scan
//   and go straight to posting the result.
//   Only one request is in work at a time; o_in_stall is high from accept
//   until the result is posted. The result register frees the input side:
//   a new request is accepted while the previous result is still stalled.
//   If the receiver stalls when a result is ready, the sequencer holds in
//   its final state until the result register is free.
//   Reset empties the table (fill level zero); the memory itself is not
//   cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_value_table_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [kvt_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [KEY_BITS-1:0]               i_req_key,
    input  wire logic [VALUE_BITS-1:0]             i_req_value,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [kvt_pkg::STATUS_W-1:0]           o_status,
    output logic                                   o_hit,
    output logic [VALUE_BITS-1:0]                  o_found_value,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]       o_match_count,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]       o_entry_total
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // table memory
    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;

    // control
    kvt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_chk_valid, n_chk_valid;
    logic             r_out_valid, n_out_valid;

    // payload
    logic [kvt_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [KEY_BITS-1:0]          r_key, n_key;
    logic [VALUE_BITS-1:0]        r_value, n_value;
    logic [AW-1:0]                r_chk_idx, n_chk_idx;
    logic                         r_hit, n_hit;
    logic [VALUE_BITS-1:0]        r_found, n_found;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [kvt_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic                         r_out_hit, n_out_hit;
    logic [VALUE_BITS-1:0]        r_out_found, n_out_found;
    logic [CNT_W-1:0]             r_out_count, n_out_count;
    logic [CNT_W-1:0]             r_out_total, n_out_total;

    // shared datapath controls
    logic                  key_mode;
    logic                  key_eq;
    logic                  val_eq;
    logic                  scan_hit;
    logic                  scan_end;
    logic                  rd_issue;
    logic                  out_free;
    logic                  tbl_full;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [KEY_BITS-1:0]   mem_wkey;
    logic [VALUE_BITS-1:0] mem_wval;

    assign key_mode = (r_mode == kvt_pkg::MODE_INSERT) || (r_mode == kvt_pkg::MODE_ERASE) ||
                      (r_mode == kvt_pkg::MODE_LOOKUP);
    assign key_eq   = (r_key_q == r_key);
    assign val_eq   = (r_val_q == r_value);
    assign scan_hit = (r_state == kvt_pkg::S_SCAN) && r_chk_valid && key_mode && key_eq;
    assign scan_end = !r_chk_valid && (r_idx >= r_fill);
    assign rd_issue = ((r_state == kvt_pkg::S_SCAN) || (r_state == kvt_pkg::S_SHIFT)) &&
                      (r_idx < r_fill);
    assign out_free = !r_out_valid || !i_out_stall;
    assign tbl_full = (r_fill == CNT_W'(TABLE_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if ((i_mode == kvt_pkg::MODE_INSERT) || (i_mode == kvt_pkg::MODE_ERASE) ||
                        (i_mode == kvt_pkg::MODE_LOOKUP) || (i_mode == kvt_pkg::MODE_COUNT)) begin
                        n_state = kvt_pkg::S_SCAN;
                    end else begin
                        n_state = kvt_pkg::S_DONE;
                    end
                end
            end
            kvt_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_mode == kvt_pkg::MODE_ERASE) ? kvt_pkg::S_SHIFT
                                                              : kvt_pkg::S_DONE;
                end else if (scan_end) begin
                    n_state = kvt_pkg::S_DONE;
                end
            end
            kvt_pkg::S_SHIFT: begin
                if (scan_end) begin
                    n_state = kvt_pkg::S_DONE;
                end
            end
            kvt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = kvt_pkg::S_IDLE;
                end
            end
            default: n_state = kvt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_chk_valid  = r_chk_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_mode       = r_mode;
        n_key        = r_key;
        n_value      = r_value;
        n_chk_idx    = r_chk_idx;
        n_hit        = r_hit;
        n_found      = r_found;
        n_count      = r_count;
        n_out_status = r_out_status;
        n_out_hit    = r_out_hit;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        n_out_total  = r_out_total;
        mem_we       = 1'b0;
        mem_waddr    = r_fill[AW-1:0];
        mem_wkey     = r_key;
        mem_wval     = r_value;

        unique case (r_state)
            kvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode      = i_mode;
                    n_key       = i_req_key;
                    n_value     = i_req_value;
                    n_idx       = '0;
                    n_chk_valid = 1'b0;
                    n_hit       = 1'b0;
                    n_found     = '0;
                    n_count     = '0;
                end
            end
            kvt_pkg::S_SCAN: begin
                n_chk_valid = rd_issue;
                n_chk_idx   = r_idx[AW-1:0];
                if (rd_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_chk_valid && (r_mode == kvt_pkg::MODE_COUNT) && val_eq) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (scan_hit) begin
                    n_hit       = 1'b1;
                    n_found     = r_val_q;
                    n_idx       = CNT_W'(r_chk_idx) + CNT_W'(1);
                    n_chk_valid = 1'b0;
                end
            end
            kvt_pkg::S_SHIFT: begin
                n_chk_valid = rd_issue;
                n_chk_idx   = r_idx[AW-1:0];
                if (rd_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_chk_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_idx - AW'(1);
                    mem_wkey  = r_key_q;
                    mem_wval  = r_val_q;
                end
            end
            kvt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = kvt_pkg::ST_OK;
                    n_out_hit    = r_hit;
                    n_out_found  = '0;
                    n_out_count  = r_count;
                    case (r_mode)
                        kvt_pkg::MODE_INSERT: begin
                            if (tbl_full) begin
                                n_out_status = kvt_pkg::ST_FULL;
                            end else if (r_hit) begin
                                n_out_status = kvt_pkg::ST_DUPLICATE;
                            end else begin
                                mem_we = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        kvt_pkg::MODE_ERASE: begin
                            if (r_hit) begin
                                n_fill = r_fill - CNT_W'(1);
                            end else begin
                                n_out_status = kvt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kvt_pkg::MODE_LOOKUP: begin
                            if (r_hit) begin
                                n_out_found = r_found;
                            end else begin
                                n_out_status = kvt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kvt_pkg::MODE_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_total = n_fill;
                end
            end
            default: begin
            end
        endcase
    end

    // table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wkey;
            val_mem[mem_waddr] <= mem_wval;
        end
        if (rd_issue) begin
            r_key_q <= key_mem[r_idx[AW-1:0]];
            r_val_q <= val_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kvt_pkg::S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_value      <= n_value;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_found      <= n_found;
        r_count      <= n_count;
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
        r_out_total  <= n_out_total;
    end

    assign o_in_stall    = (r_state != kvt_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_hit         = r_out_hit;
    assign o_found_value = r_out_found;
    assign o_match_count = r_out_count;
    assign o_entry_total = r_out_total;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill level above table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but sequencer not busy");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> ((r_state == kvt_pkg::S_SCAN) || (r_state == kvt_pkg::S_SHIFT)))
        else $error("pending compare outside scan or shift");

    a_post_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kvt_pkg::S_DONE) && out_free) |=> r_out_valid)
        else $error("result not posted on completion");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvt_pkg::S_DONE) |-> (r_count <= r_fill))
        else $error("match count above fill level");

endmodule

`default_nettype wire
